### hw/rtl/lav_pkg.sv
// Shared constants, types and state encodings of the look-at view matrix block.
package lav_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int D_W       = IN_W + 1;
    localparam int AX_W      = FRAC_BITS + 2;
    localparam int YA_W      = FRAC_BITS + 3;
    localparam int PR_W      = IN_W + YA_W;
    localparam int CR_W      = PR_W;
    localparam int ACC_W     = PR_W + 2;
    localparam int SQ_W      = 63;
    localparam int LEN_W     = 31;
    localparam int DC_W      = $clog2(FRAC_BITS + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int K_W       = 5;

    localparam logic [K_W-1:0] K_CR_LAST = 5'd5;
    localparam logic [K_W-1:0] K_YT_LAST = 5'd20;
    localparam logic [1:0]     ROW_LAST  = 2'd3;
    localparam logic [16:0]    ONE_E3    = 17'((64'd1 << FRAC_BITS) & 64'h1FFFF);

    typedef struct packed {
        logic [2:0][IN_W-1:0] eye;
        logic [2:0][IN_W-1:0] up;
        logic [2:0][D_W-1:0]  d;
    } t_item;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIV
    } t_nstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_NZ_WAIT,
        B_MAC_CR,
        B_CR_DRAIN,
        B_NX_START,
        B_NX_WAIT,
        B_MAC_YT,
        B_T_DRAIN,
        B_OUT
    } t_bstate;

endpackage

### hw/rtl/lav_front.sv
// Front end: takes input transfers, forms eye minus target and queues the items.
module lav_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_eye_x,
    input  logic signed [31:0]  i_eye_y,
    input  logic signed [31:0]  i_eye_z,
    input  logic signed [31:0]  i_target_x,
    input  logic signed [31:0]  i_target_y,
    input  logic signed [31:0]  i_target_z,
    input  logic signed [31:0]  i_up_x,
    input  logic signed [31:0]  i_up_y,
    input  logic signed [31:0]  i_up_z,
    input  logic                i_pop,
    output logic                o_busy,
    output logic                o_valid,
    output lav_pkg::t_item      o_item
);
    import lav_pkg::*;

    t_item                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic                 push;
    t_item                n_item;

    assign o_busy  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_start && !o_busy;
    assign o_item  = r_q[r_rd];

    always_comb begin
        n_item.eye = {i_eye_z, i_eye_y, i_eye_x};
        n_item.up  = {i_up_z, i_up_y, i_up_x};
        n_item.d[0] = D_W'(i_eye_x) - D_W'(i_target_x);
        n_item.d[1] = D_W'(i_eye_y) - D_W'(i_target_y);
        n_item.d[2] = D_W'(i_eye_z) - D_W'(i_target_z);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/lav_norm.sv
// Iterative vector normalize: shift alignment, sum of squares, square root and division.
module lav_norm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [lav_pkg::CR_W-1:0]    i_vec [3],
    output logic                               o_done,
    output logic                               o_zero,
    output logic signed [lav_pkg::AX_W-1:0]    o_res [3]
);
    import lav_pkg::*;

    t_nstate                r_state;
    t_nstate                n_state;
    logic [CR_W-1:0]        r_m [3];
    logic                   r_s [3];
    logic [CR_W-1:0]        all_m;
    logic                   in_zero;
    logic [1:0]             r_cnt;
    logic [59:0]            r_sq;
    logic [61:0]            r_sum;
    logic [CR_W-1:0]        sq_sel;
    logic [SQ_W-1:0]        r_rn;
    logic [SQ_W-1:0]        r_rr;
    logic [SQ_W-1:0]        r_rbit;
    logic [SQ_W:0]          sq_t;
    logic                   sq_ge;
    logic [SQ_W-1:0]        rr_next;
    logic [LEN_W-1:0]       r_len;
    logic [1:0]             r_ci;
    logic [DC_W-1:0]        r_dc;
    logic [LEN_W-1:0]       r_rem;
    logic [FRAC_BITS:0]     r_q;
    logic [CR_W-1:0]        m_cur;
    logic [CR_W-1:0]        m_nxt;
    logic [LEN_W:0]         dv_t;
    logic                   dv_ge;
    logic [FRAC_BITS:0]     q_fin;
    logic signed [AX_W-1:0] q_pos;
    logic                   r_done;
    logic                   r_zero;
    logic signed [AX_W-1:0] r_res [3];

    assign all_m   = r_m[0] | r_m[1] | r_m[2];
    assign in_zero = (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0);

    always_comb begin
        unique case (r_cnt)
            2'd0:    sq_sel = r_m[0];
            2'd1:    sq_sel = r_m[1];
            2'd2:    sq_sel = r_m[2];
            default: sq_sel = '0;
        endcase
        unique case (r_ci)
            2'd0:    begin m_cur = r_m[0]; m_nxt = r_m[1]; end
            2'd1:    begin m_cur = r_m[1]; m_nxt = r_m[2]; end
            default: begin m_cur = r_m[2]; m_nxt = r_m[2]; end
        endcase
    end

    assign sq_t    = {1'b0, r_rr} + {1'b0, r_rbit};
    assign sq_ge   = ({1'b0, r_rn} >= sq_t);
    assign rr_next = sq_ge ? ((r_rr >> 1) + r_rbit) : (r_rr >> 1);

    assign dv_t  = {r_rem, (r_dc == '0) ? m_cur[0] : 1'b0};
    assign dv_ge = (dv_t >= {1'b0, r_len});
    assign q_fin = {r_q[FRAC_BITS-1:0], dv_ge};
    assign q_pos = AX_W'({1'b0, q_fin});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            N_IDLE: begin
                if (i_start && !in_zero) begin
                    n_state = N_SHIFT;
                end
            end
            N_SHIFT: begin
                if (~|all_m[CR_W-1:30] && all_m[29]) begin
                    n_state = N_SQ;
                end
            end
            N_SQ: begin
                if (r_cnt == 2'd3) begin
                    n_state = N_SQRT;
                end
            end
            N_SQRT: begin
                if ((r_rbit >> 2) == '0) begin
                    n_state = N_DIV;
                end
            end
            N_DIV: begin
                if (r_dc == DC_W'(FRAC_BITS) && r_ci == 2'd2) begin
                    n_state = N_IDLE;
                end
            end
            default: n_state = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == N_IDLE && i_start && in_zero) ||
                      (r_state == N_DIV && r_dc == DC_W'(FRAC_BITS) && r_ci == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    r_zero <= in_zero;
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= i_vec[i][CR_W-1] ? CR_W'(-i_vec[i]) : CR_W'(i_vec[i]);
                        r_s[i] <= i_vec[i][CR_W-1];
                        if (in_zero) begin
                            r_res[i] <= '0;
                        end
                    end
                end
            end
            N_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    if (|all_m[CR_W-1:30]) begin
                        r_m[i] <= r_m[i] >> 1;
                    end else if (!all_m[29]) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end
                r_cnt <= '0;
                r_sum <= '0;
            end
            N_SQ: begin
                r_sq  <= sq_sel[29:0] * sq_sel[29:0];
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt != 2'd0) begin
                    r_sum <= r_sum + 62'(r_sq);
                end
                r_rn   <= SQ_W'(r_sum) + SQ_W'(r_sq);
                r_rr   <= '0;
                r_rbit <= SQ_W'(1) << (SQ_W - 1);
            end
            N_SQRT: begin
                if (sq_ge) begin
                    r_rn <= r_rn - sq_t[SQ_W-1:0];
                end
                r_rr   <= rr_next;
                r_rbit <= r_rbit >> 2;
                r_len  <= rr_next[LEN_W-1:0];
                r_ci   <= '0;
                r_dc   <= '0;
                r_q    <= '0;
                r_rem  <= LEN_W'(r_m[0] >> 1);
            end
            N_DIV: begin
                if (r_dc == DC_W'(FRAC_BITS)) begin
                    r_res[r_ci] <= r_s[r_ci] ? -q_pos : q_pos;
                    r_ci  <= r_ci + 2'd1;
                    r_dc  <= '0;
                    r_q   <= '0;
                    r_rem <= LEN_W'(m_nxt >> 1);
                end else begin
                    r_dc  <= r_dc + 1'b1;
                    r_q   <= q_fin;
                    r_rem <= dv_ge ? LEN_W'(dv_t - {1'b0, r_len}) : dv_t[LEN_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_zero = r_zero;
    assign o_res  = r_res;

endmodule

### hw/rtl/lav_back.sv
// Back end: sequences both normalizes, the shared multiply-accumulate and the row output.
module lav_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  lav_pkg::t_item      i_item,
    output logic                o_pop,
    output logic                o_valid,
    output logic [1:0]          o_row_index,
    output logic signed [31:0]  o_entry0,
    output logic signed [31:0]  o_entry1,
    output logic signed [31:0]  o_entry2,
    output logic [16:0]         o_entry3,
    output logic                o_last_row,
    output logic                o_degenerate
);
    import lav_pkg::*;

    t_bstate                 r_state;
    t_bstate                 n_state;
    logic signed [IN_W-1:0]  r_eye [3];
    logic signed [IN_W-1:0]  r_up [3];
    logic signed [AX_W-1:0]  r_zc [3];
    logic signed [AX_W-1:0]  r_xa [3];
    logic signed [YA_W-1:0]  r_ya [3];
    logic signed [CR_W-1:0]  r_cr [3];
    logic signed [31:0]      r_tr [3];
    logic                    r_degen;
    logic [K_W-1:0]          r_k;
    logic [1:0]              r_row;
    logic                    issue;
    logic signed [IN_W-1:0]  mul_a;
    logic signed [YA_W-1:0]  mul_b;
    logic signed [PR_W-1:0]  r_prod;
    logic                    r_pv;
    logic [K_W-1:0]          r_pk;
    logic                    acc_first;
    logic                    acc_neg;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] acc_new;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [31:0]      acc_sat;
    logic                    nrm_start;
    logic signed [CR_W-1:0]  nrm_in [3];
    logic                    nrm_done;
    logic                    nrm_zero;
    logic signed [AX_W-1:0]  nrm_res [3];

    assign issue     = (r_state == B_MAC_CR) || (r_state == B_MAC_YT);
    assign o_pop     = (r_state == B_IDLE) && i_valid;
    assign nrm_start = o_pop || (r_state == B_NX_START);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nrm_in[i] = (r_state == B_IDLE) ? CR_W'($signed(i_item.d[i])) : r_cr[i];
        end
    end

    lav_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nrm_start),
        .i_vec   (nrm_in),
        .o_done  (nrm_done),
        .o_zero  (nrm_zero),
        .o_res   (nrm_res)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_k)
            5'd0:  begin mul_a = r_up[1]; mul_b = YA_W'(r_zc[2]); end
            5'd1:  begin mul_a = r_up[2]; mul_b = YA_W'(r_zc[1]); end
            5'd2:  begin mul_a = r_up[2]; mul_b = YA_W'(r_zc[0]); end
            5'd3:  begin mul_a = r_up[0]; mul_b = YA_W'(r_zc[2]); end
            5'd4:  begin mul_a = r_up[0]; mul_b = YA_W'(r_zc[1]); end
            5'd5:  begin mul_a = r_up[1]; mul_b = YA_W'(r_zc[0]); end
            5'd6:  begin mul_a = IN_W'(r_zc[1]); mul_b = YA_W'(r_xa[2]); end
            5'd7:  begin mul_a = IN_W'(r_zc[2]); mul_b = YA_W'(r_xa[1]); end
            5'd8:  begin mul_a = IN_W'(r_zc[2]); mul_b = YA_W'(r_xa[0]); end
            5'd9:  begin mul_a = IN_W'(r_zc[0]); mul_b = YA_W'(r_xa[2]); end
            5'd10: begin mul_a = IN_W'(r_zc[0]); mul_b = YA_W'(r_xa[1]); end
            5'd11: begin mul_a = IN_W'(r_zc[1]); mul_b = YA_W'(r_xa[0]); end
            5'd12: begin mul_a = r_eye[0]; mul_b = YA_W'(r_xa[0]); end
            5'd13: begin mul_a = r_eye[1]; mul_b = YA_W'(r_xa[1]); end
            5'd14: begin mul_a = r_eye[2]; mul_b = YA_W'(r_xa[2]); end
            5'd15: begin mul_a = r_eye[0]; mul_b = r_ya[0]; end
            5'd16: begin mul_a = r_eye[1]; mul_b = r_ya[1]; end
            5'd17: begin mul_a = r_eye[2]; mul_b = r_ya[2]; end
            5'd18: begin mul_a = r_eye[0]; mul_b = YA_W'(r_zc[0]); end
            5'd19: begin mul_a = r_eye[1]; mul_b = YA_W'(r_zc[1]); end
            5'd20: begin mul_a = r_eye[2]; mul_b = YA_W'(r_zc[2]); end
            default: begin end
        endcase
    end

    always_comb begin
        acc_first = 1'b0;
        unique case (r_pk)
            5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd15, 5'd18: acc_first = 1'b1;
            default: acc_first = 1'b0;
        endcase
        acc_neg  = (r_pk >= 5'd12) || r_pk[0];
        prod_ext = ACC_W'(r_prod);
        acc_new  = (acc_first ? ACC_W'(0) : r_acc) + (acc_neg ? -prod_ext : prod_ext);
        acc_sh   = acc_new >>> FRAC_BITS;
        if (&acc_sh[ACC_W-1:31] || ~|acc_sh[ACC_W-1:31]) begin
            acc_sat = acc_sh[31:0];
        end else begin
            acc_sat = acc_sh[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:     if (i_valid) n_state = B_NZ_WAIT;
            B_NZ_WAIT:  if (nrm_done) n_state = B_MAC_CR;
            B_MAC_CR:   if (r_k == K_CR_LAST) n_state = B_CR_DRAIN;
            B_CR_DRAIN: n_state = B_NX_START;
            B_NX_START: n_state = B_NX_WAIT;
            B_NX_WAIT:  if (nrm_done) n_state = B_MAC_YT;
            B_MAC_YT:   if (r_k == K_YT_LAST) n_state = B_T_DRAIN;
            B_T_DRAIN:  n_state = B_OUT;
            B_OUT:      if (r_row == ROW_LAST) n_state = B_IDLE;
            default:    n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < 3; i++) begin
                r_eye[i] <= $signed(i_item.eye[i]);
                r_up[i]  <= $signed(i_item.up[i]);
            end
            r_k <= '0;
        end
        if (issue) begin
            r_k <= r_k + 1'b1;
        end
        if (nrm_done && r_state == B_NZ_WAIT) begin
            r_zc    <= nrm_res;
            r_degen <= nrm_zero;
        end
        if (nrm_done && r_state == B_NX_WAIT) begin
            r_xa    <= nrm_res;
            r_degen <= r_degen | nrm_zero;
        end
        r_prod <= mul_a * mul_b;
        r_pk   <= r_k;
        if (r_pv) begin
            r_acc <= acc_new;
            unique case (r_pk)
                5'd1:    r_cr[0] <= acc_new[CR_W-1:0];
                5'd3:    r_cr[1] <= acc_new[CR_W-1:0];
                5'd5:    r_cr[2] <= acc_new[CR_W-1:0];
                5'd7:    r_ya[0] <= acc_sh[YA_W-1:0];
                5'd9:    r_ya[1] <= acc_sh[YA_W-1:0];
                5'd11:   r_ya[2] <= acc_sh[YA_W-1:0];
                5'd14:   r_tr[0] <= acc_sat;
                5'd17:   r_tr[1] <= acc_sat;
                5'd20:   r_tr[2] <= acc_sat;
                default: begin end
            endcase
        end
        if (r_state == B_T_DRAIN) begin
            r_row <= '0;
        end else if (r_state == B_OUT) begin
            r_row <= r_row + 2'd1;
        end
        o_row_index  <= r_row;
        o_last_row   <= (r_row == ROW_LAST);
        o_entry3     <= (r_row == ROW_LAST) ? ONE_E3 : 17'd0;
        o_degenerate <= r_degen;
        unique case (r_row)
            2'd0: begin
                o_entry0 <= 32'(r_xa[0]); o_entry1 <= 32'(r_ya[0]); o_entry2 <= 32'(r_zc[0]);
            end
            2'd1: begin
                o_entry0 <= 32'(r_xa[1]); o_entry1 <= 32'(r_ya[1]); o_entry2 <= 32'(r_zc[1]);
            end
            2'd2: begin
                o_entry0 <= 32'(r_xa[2]); o_entry1 <= 32'(r_ya[2]); o_entry2 <= 32'(r_zc[2]);
            end
            default: begin
                o_entry0 <= r_tr[0]; o_entry1 <= r_tr[1]; o_entry2 <= r_tr[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_pv    <= issue;
            o_valid <= (r_state == B_OUT);
        end
    end

endmodule

### hw/rtl/look_at_view_matrix.sv
// Top level of the fixed point look-at view matrix block.
//
// Channel  Direction  Handshake           Payload
// input    in         i_start / o_busy    eye, target and up vectors, Q16.16
// result   out        o_valid strobe      row index, four entries, last row, degenerate
//
// Each item yields four rows on consecutive cycles, row 0 first; the back end takes one item
// at a time, mostly spent in two normalizes (align, square, root, divide). A zero direction
// or a zero cross product skips those steps in its normalize.
// A two-entry queue takes new transfers while the back end works; busy is high when it is full.
// Reset is synchronous and active low and empties the queue and the sequencers.
// Results cannot be stalled; each row appears for exactly one cycle.
module look_at_view_matrix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_eye_x,
    input  logic signed [31:0]  i_eye_y,
    input  logic signed [31:0]  i_eye_z,
    input  logic signed [31:0]  i_target_x,
    input  logic signed [31:0]  i_target_y,
    input  logic signed [31:0]  i_target_z,
    input  logic signed [31:0]  i_up_x,
    input  logic signed [31:0]  i_up_y,
    input  logic signed [31:0]  i_up_z,
    output logic                o_busy,
    output logic                o_valid,
    output logic [1:0]          o_row_index,
    output logic signed [31:0]  o_entry0,
    output logic signed [31:0]  o_entry1,
    output logic signed [31:0]  o_entry2,
    output logic [16:0]         o_entry3,
    output logic                o_last_row,
    output logic                o_degenerate
);
    import lav_pkg::*;

    t_item q_item;
    logic  q_valid;
    logic  q_pop;

    lav_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_eye_x    (i_eye_x),
        .i_eye_y    (i_eye_y),
        .i_eye_z    (i_eye_z),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_target_z (i_target_z),
        .i_up_x     (i_up_x),
        .i_up_y     (i_up_y),
        .i_up_z     (i_up_z),
        .i_pop      (q_pop),
        .o_busy     (o_busy),
        .o_valid    (q_valid),
        .o_item     (q_item)
    );

    lav_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_row_index  (o_row_index),
        .o_entry0     (o_entry0),
        .o_entry1     (o_entry1),
        .o_entry2     (o_entry2),
        .o_entry3     (o_entry3),
        .o_last_row   (o_last_row),
        .o_degenerate (o_degenerate)
    );

endmodule

### hw/rtl/lav_checker.sv
// Port-level checks on the row sequence of the look-at view matrix block.
module lav_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic [1:0]  o_row_index,
    input  logic [16:0] o_entry3,
    input  logic        o_last_row,
    input  logic        o_degenerate
);

    a_rows_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_row) |=> (o_valid && o_row_index == $past(o_row_index) + 2'd1))
        else $error("rows of one item are not consecutive");

    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> (o_row_index == 2'd0))
        else $error("an item does not start at row 0");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == 2'd3)))
        else $error("last row flag disagrees with row index");

    a_degen_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_row_index != 2'd0) |-> $stable(o_degenerate))
        else $error("degenerate flag changed within an item");

    a_entry3_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_row) |-> (o_entry3 == 17'd0))
        else $error("fourth entry not zero on an axis row");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);

### test/testbench.sv
// Self-checking testbench for the look-at view matrix block, driven from a queue of camera items.
module testbench;
    import lav_pkg::*;

    typedef struct {
        logic [31:0] eye_x, eye_y, eye_z, tgt_x, tgt_y, tgt_z, up_x, up_y, up_z;
        int          gap_pct;
        bit          drain_first;
    } t_camera;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] e0, e1, e2;
        logic [16:0] e3;
        logic        last;
        logic        degen;
    } t_matrix_row;

    logic        i_clk, i_rst_n, i_start;
    logic signed [31:0] i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z;
    logic signed [31:0] i_up_x, i_up_y, i_up_z;
    logic        o_busy, o_valid, o_last_row, o_degenerate;
    logic [1:0]  o_row_index;
    logic signed [31:0] o_entry0, o_entry1, o_entry2;
    logic [16:0] o_entry3;

    t_camera     cameras[$];
    t_matrix_row rows_due[$];
    t_camera     in_flight;
    int          mismatches = 0;
    int          items_sent = 0;
    int          rows_seen = 0;
    int          degen_rows = 0;

    look_at_view_matrix DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit_vec(input longint a, input longint b, input longint c,
                                    output longint ua, output longint ub, output longint uc);
        longint unsigned m[3];
        longint unsigned all, sum, len;
        longint          v[3];
        longint          u[3];
        int              hb;
        v[0] = a; v[1] = b; v[2] = c;
        for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
        all = m[0] | m[1] | m[2];
        ua = 0; ub = 0; uc = 0;
        if (all == 0) return 1'b0;
        hb = 0;
        for (int i = 0; i < 64; i++) if (all[i]) hb = i;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (hb > 29) m[i] = m[i] >> (hb - 29);
            else m[i] = m[i] << (29 - hb);
            sum = sum + m[i] * m[i];
        end
        len = floor_root(sum);
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'((m[i] << FRAC_BITS) / len);
            if (v[i] < 0) u[i] = -u[i];
        end
        ua = u[0]; ub = u[1]; uc = u[2];
        return 1'b1;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    task automatic predict_view_rows(input t_camera c);
        longint eye[3], up[3], z[3], x[3], y[3], cr[3], tr[3];
        bit     degen;
        t_matrix_row r;
        eye[0] = longint'($signed(c.eye_x));
        eye[1] = longint'($signed(c.eye_y));
        eye[2] = longint'($signed(c.eye_z));
        up[0]  = longint'($signed(c.up_x));
        up[1]  = longint'($signed(c.up_y));
        up[2]  = longint'($signed(c.up_z));
        degen = !unit_vec(eye[0] - longint'($signed(c.tgt_x)),
                          eye[1] - longint'($signed(c.tgt_y)),
                          eye[2] - longint'($signed(c.tgt_z)), z[0], z[1], z[2]);
        cr[0] = up[1] * z[2] - up[2] * z[1];
        cr[1] = up[2] * z[0] - up[0] * z[2];
        cr[2] = up[0] * z[1] - up[1] * z[0];
        if (!unit_vec(cr[0], cr[1], cr[2], x[0], x[1], x[2])) degen = 1'b1;
        y[0] = (z[1] * x[2] - z[2] * x[1]) >>> FRAC_BITS;
        y[1] = (z[2] * x[0] - z[0] * x[2]) >>> FRAC_BITS;
        y[2] = (z[0] * x[1] - z[1] * x[0]) >>> FRAC_BITS;
        tr[0] = -(x[0] * eye[0] + x[1] * eye[1] + x[2] * eye[2]);
        tr[1] = -(y[0] * eye[0] + y[1] * eye[1] + y[2] * eye[2]);
        tr[2] = -(z[0] * eye[0] + z[1] * eye[1] + z[2] * eye[2]);
        for (int i = 0; i < 4; i++) begin
            r.row   = 2'(i);
            r.degen = degen;
            r.last  = (i == 3);
            if (i < 3) begin
                r.e0 = x[i][31:0];
                r.e1 = y[i][31:0];
                r.e2 = z[i][31:0];
                r.e3 = '0;
            end else begin
                r.e0 = clamp32(tr[0] >>> FRAC_BITS);
                r.e1 = clamp32(tr[1] >>> FRAC_BITS);
                r.e2 = clamp32(tr[2] >>> FRAC_BITS);
                r.e3 = 17'((64'd1 << FRAC_BITS) & 64'h1FFFF);
            end
            rows_due.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                predict_view_rows(in_flight);
                items_sent++;
            end
            if (!(i_start && o_busy)) begin
                if (cameras.size() != 0 && $urandom_range(99) >= cameras[0].gap_pct
                        && (!cameras[0].drain_first || rows_due.size() == 0)) begin
                    in_flight = cameras.pop_front();
                    i_start    <= 1'b1;
                    i_eye_x    <= in_flight.eye_x;
                    i_eye_y    <= in_flight.eye_y;
                    i_eye_z    <= in_flight.eye_z;
                    i_target_x <= in_flight.tgt_x;
                    i_target_y <= in_flight.tgt_y;
                    i_target_z <= in_flight.tgt_z;
                    i_up_x     <= in_flight.up_x;
                    i_up_y     <= in_flight.up_y;
                    i_up_z     <= in_flight.up_z;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_matrix_row r;
        if (i_rst_n && o_valid) begin
            rows_seen++;
            if (o_degenerate) degen_rows++;
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected row %0d with nothing pending.",
                                               o_row_index);
            end else begin
                r = rows_due.pop_front();
                if (o_row_index !== r.row || o_entry0 !== r.e0 || o_entry1 !== r.e1
                        || o_entry2 !== r.e2 || o_entry3 !== r.e3
                        || o_last_row !== r.last || o_degenerate !== r.degen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Row mismatch: expected %0d %h %h %h %h %b %b,",
                                 r.row, r.e0, r.e1, r.e2, r.e3, r.last, r.degen,
                                 " got %0d %h %h %h %h %b %b",
                                 o_row_index, o_entry0, o_entry1, o_entry2, o_entry3,
                                 o_last_row, o_degenerate);
                end
            end
        end
    end

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097152)) - 1048576);
            default: return 32'($signed($urandom_range(16)) - 8);
        endcase
    endfunction

    task automatic add_camera(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz,
                              input int gap, input bit drain);
        t_camera c;
        c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
        c.tgt_x = tx; c.tgt_y = ty; c.tgt_z = tz;
        c.up_x = ux;  c.up_y = uy;  c.up_z = uz;
        c.gap_pct = gap;
        c.drain_first = drain;
        cameras.push_back(c);
    endtask

    initial begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [31:0] MINV = 32'h8000_0000;
        int gap, mode, upm;
        logic [31:0] ex, ey, ez;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        {i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z} = '0;
        {i_up_x, i_up_y, i_up_z} = '0;

        add_camera(0, 0, 5*ONE, 0, 0, 0, 0, ONE, 0, 0, 0);
        add_camera(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, ONE, 0, 0, 0);
        add_camera(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_camera(0, 4*ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0);
        add_camera(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_camera(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, ONE, 0, 0, 0);
        add_camera(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, 0, 0);
        add_camera(MAXV, MINV, MAXV, 0, 0, 0, MINV, MAXV, 0, 0, 0);
        add_camera(MINV, 0, 0, MAXV, 0, ONE, 0, MAXV, 0, 0, 0);
        add_camera(MAXV, 0, 0, MAXV - 1, 0, 0, 0, 0, MINV, 0, 0);
        add_camera(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1);
        add_camera(MAXV, MAXV, 0, 0, 0, MAXV, 1, 1, 1, 0, 0);
        add_camera(32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, MINV, MINV, MINV, 0, 0);
        add_camera(3*ONE, 0, 4*ONE, 0, 0, 0, 0, ONE, 0, 0, 0);
        add_camera(0, MAXV, 0, 0, MINV, 0, MINV, 0, 0, 0, 0);

        for (int i = 0; i < 155; i++) begin
            gap  = (i < 40) ? 0 : (i < 85) ? 52 : (i < 130) ? 36 : 52 * (i % 2);
            mode = $urandom_range(9) < 4 ? 0 : ($urandom_range(9) < 7 ? 1 : 2);
            upm  = $urandom_range(9);
            ex = rand_coord(mode); ey = rand_coord(mode); ez = rand_coord(mode);
            if (upm < 4)
                add_camera(ex, ey, ez, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                           0, ONE, 0, gap, i == 100);
            else if (upm == 4)
                add_camera(ex, ey, ez, ex, ey, ez, rand_coord(0), rand_coord(0),
                           rand_coord(0), gap, i == 100);
            else
                add_camera(ex, ey, ez, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                           rand_coord(mode), rand_coord(mode), rand_coord(mode), gap,
                           i == 100);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cameras.size() != 0 || i_start || rows_due.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("Sent %0d camera items and checked %0d matrix rows, %0d of them degenerate.",
                 items_sent, rows_seen, degen_rows);
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("look_at_view_matrix verification clean");
        end else begin
            $display("Mismatches: %0d.", mismatches);
            $display("look_at_view_matrix verification failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("look_at_view_matrix verification failed");
        $finish;
    end
endmodule

### files.f
hw/rtl/lav_pkg.sv
hw/rtl/lav_front.sv
hw/rtl/lav_norm.sv
hw/rtl/lav_back.sv
hw/rtl/look_at_view_matrix.sv
hw/rtl/lav_checker.sv
test/testbench.sv
